[rtl/tga_rle_pkg.sv]
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; imported by every module of the block.
package tga_rle_pkg;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int OUT_DATA_W  = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA   = 4'd1;

    // Packet header coding
    localparam int                HDR_RUN_BIT = 7;
    localparam logic [BYTE_W-1:0] RUN_BIAS    = 8'd127;

    // Byte positions within a pixel (blue, green, red, alpha)
    localparam logic [1:0] POS_RED   = 2'd2;
    localparam logic [1:0] POS_ALPHA = 2'd3;

    // One decoded result
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic [BYTE_W-1:0] repeat_res;
        logic              last_of_image;
    } pix_res_t;

    // Configuration write from the port
    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

[rtl/tga_rle_in_reg.sv]
// Input register of the TGA run-length decoder: holds one coded byte.
// Depends on tga_rle_pkg.
module tga_rle_in_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [tga_rle_pkg::BYTE_W-1:0] s_axis_tdata,
    input  logic                        take,
    output logic                        hold_valid,
    output logic [tga_rle_pkg::BYTE_W-1:0] hold_byte
);
    import tga_rle_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // Accept a new word when empty or when the held word leaves this cycle
    assign s_axis_tready = !valid_reg || take;
    assign hold_valid    = valid_reg;
    assign hold_byte     = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on accept
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_reg <= s_axis_tdata;
        end
    end

endmodule

[rtl/tga_rle_core.sv]
// Packet and pixel state of the TGA run-length decoder, with the configuration registers.
// Depends on tga_rle_pkg.
module tga_rle_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tga_rle_pkg::cfg_wr_t           cfg,
    input  logic                           hold_valid,
    input  logic [tga_rle_pkg::BYTE_W-1:0] hold_byte,
    input  logic                           out_free,
    output logic                           take,
    output logic                           res_load,
    output tga_rle_pkg::pix_res_t          res
);
    import tga_rle_pkg::*;

    logic [COUNT_W-1:0] img_size_reg;
    logic [COUNT_W-1:0] img_size_next;
    logic               has_alpha_reg;
    logic               has_alpha_next;
    logic               exp_hdr_reg;
    logic               exp_hdr_next;
    logic               run_reg;
    logic               run_next;
    logic [BYTE_W-1:0]  ppl_reg;
    logic [BYTE_W-1:0]  ppl_next;
    logic [1:0]         pos_reg;
    logic [1:0]         pos_next;
    logic [BYTE_W-1:0]  color_reg [3];
    logic [BYTE_W-1:0]  color_next [3];
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] rem_next;

    logic               completes;
    logic [BYTE_W-1:0]  rep;
    logic [COUNT_W-1:0] rem_after;
    logic               done;
    logic [BYTE_W-1:0]  ppl_after;
    logic [COUNT_W-1:0] cfg_size;

    // A data byte closes a pixel once the last byte position is reached
    assign completes = hold_valid && !exp_hdr_reg &&
                       (has_alpha_reg ? (pos_reg == POS_ALPHA) : (pos_reg >= POS_RED));
    assign take      = hold_valid && (!completes || out_free);
    assign res_load  = completes && out_free;

    // Repeat count clipped to the pixels left, and the count after this result
    always_comb
    begin
        rep       = 8'd1;
        ppl_after = (ppl_reg != '0) ? ppl_reg - 8'd1 : '0;
        if (run_reg)
        begin
            ppl_after = '0;
            if ({{(COUNT_W-BYTE_W){1'b0}}, ppl_reg} > rem_reg)
            begin
                rep = rem_reg[BYTE_W-1:0];
            end
            else
            begin
                rep = ppl_reg;
            end
        end
        rem_after = rem_reg - {{(COUNT_W-BYTE_W){1'b0}}, rep};
        done      = (rem_after == '0);
    end

    // Result fields
    always_comb
    begin
        res.red           = (pos_reg == POS_RED) ? hold_byte : color_reg[2];
        res.green         = color_reg[1];
        res.blue          = color_reg[0];
        res.alpha         = (has_alpha_reg && pos_reg == POS_ALPHA) ? hold_byte : '0;
        res.repeat_res    = rep;
        res.last_of_image = done;
    end

    assign cfg_size = (cfg.data == '0) ? {{(COUNT_W-1){1'b0}}, 1'b1} : cfg.data;

    // Next state: configuration writes, then header and pixel bytes
    always_comb
    begin
        img_size_next  = img_size_reg;
        has_alpha_next = has_alpha_reg;
        exp_hdr_next   = exp_hdr_reg;
        run_next       = run_reg;
        ppl_next       = ppl_reg;
        pos_next       = pos_reg;
        color_next     = color_reg;
        rem_next       = rem_reg;
        if (cfg.valid && cfg.index == CFG_PIXEL_COUNT)
        begin
            img_size_next = cfg_size;
            exp_hdr_next  = 1'b1;
            run_next      = 1'b0;
            ppl_next      = '0;
            pos_next      = '0;
            rem_next      = cfg_size;
        end
        else if (cfg.valid && cfg.index == CFG_HAS_ALPHA)
        begin
            has_alpha_next = cfg.data[0];
        end
        else if (take)
        begin
            priority if (exp_hdr_reg)
            begin
                exp_hdr_next = 1'b0;
                pos_next     = '0;
                run_next     = hold_byte[HDR_RUN_BIT];
                ppl_next     = hold_byte[HDR_RUN_BIT] ? hold_byte - RUN_BIAS
                                                      : hold_byte + 8'd1;
            end
            else if (!completes)
            begin
                color_next[pos_reg] = hold_byte;
                pos_next            = pos_reg + 2'd1;
            end
            else
            begin
                if (pos_reg != POS_ALPHA)
                begin
                    color_next[pos_reg] = hold_byte;
                end
                pos_next = '0;
                if (done)
                begin
                    exp_hdr_next = 1'b1;
                    run_next     = 1'b0;
                    ppl_next     = '0;
                    rem_next     = img_size_reg;
                end
                else
                begin
                    ppl_next     = ppl_after;
                    rem_next     = rem_after;
                    exp_hdr_next = (ppl_after == '0);
                end
            end
        end
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_size_reg  <= {{(COUNT_W-1){1'b0}}, 1'b1};
            has_alpha_reg <= 1'b0;
            exp_hdr_reg   <= 1'b1;
            run_reg       <= 1'b0;
            ppl_reg       <= '0;
            pos_reg       <= '0;
            color_reg     <= '{default: '0};
            rem_reg       <= {{(COUNT_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            img_size_reg  <= img_size_next;
            has_alpha_reg <= has_alpha_next;
            exp_hdr_reg   <= exp_hdr_next;
            run_reg       <= run_next;
            ppl_reg       <= ppl_next;
            pos_reg       <= pos_next;
            color_reg     <= color_next;
            rem_reg       <= rem_next;
        end
    end

    // Checks
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != '0)
        else $error("pixels remaining reached zero without rearming");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        img_size_reg != '0)
        else $error("image size register holds zero");

    a_ppl_range: assert property (@(posedge clk) disable iff (!rst_n)
        ppl_reg <= 8'd128)
        else $error("packet pixel count above 128");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.last_of_image && !cfg.valid) |=>
        (exp_hdr_reg && rem_reg == img_size_reg && pos_reg == '0))
        else $error("decoder did not rearm after the final pixel");

    a_rep_fits: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> ({{(COUNT_W-BYTE_W){1'b0}}, res.repeat_res} <= rem_reg &&
                      res.repeat_res != '0))
        else $error("repeat count outside the pixels remaining");

endmodule

[rtl/tga_rle_out_reg.sv]
// Result register of the TGA run-length decoder: packs one pixel result on the output stream.
// Depends on tga_rle_pkg.
module tga_rle_out_reg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               res_load,
    input  tga_rle_pkg::pix_res_t              res,
    output logic                               out_free,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tga_rle_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                               m_axis_tlast
);
    import tga_rle_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [OUT_DATA_W-1:0] data_reg;
    logic                  last_reg;

    // Free when empty or when the held word is taken this cycle
    assign out_free      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Pack red lowest, then green, blue, alpha, repeat count
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= {res.repeat_res, res.alpha, res.blue, res.green, res.red};
            last_reg <= res.last_of_image;
        end
    end

endmodule

[rtl/tga_rle_pixel_decoder_unit.sv]
// Top level of the TGA run-length pixel decoder.
// Depends on tga_rle_pkg, tga_rle_in_reg, tga_rle_core and tga_rle_out_reg.
//
//   channel  direction  width  contents
//   s_axis   in         8      byte_in
//   m_axis   out        40+1   red, green, blue, alpha, repeat_res; tlast = last_of_image
//   cfg      in         4+32   index 0 pixel_count, index 1 has_alpha
//
// One byte is taken per cycle while no completing byte waits on a stalled output; each
// byte is held in the input register until the core takes it, and a completed pixel is
// loaded from there into the result register, which presents its word on m_axis.
// Throughput is set by the state update of the decode core. A stalled output holds only
// bytes that complete a pixel; header and partial-pixel bytes keep flowing. Reset rearms
// for a one-pixel image with no alpha; cfg_ready is always high.
module tga_rle_pixel_decoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // byte_in [7:0]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tga_rle_pkg::BYTE_W-1:0]      s_axis_tdata,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24], repeat_res [39:32]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tga_rle_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tga_rle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tga_rle_pkg::*;

    logic              take;
    logic              hold_valid;
    logic [BYTE_W-1:0] hold_byte;
    logic              out_free;
    logic              res_load;
    pix_res_t          res;
    cfg_wr_t           cfg;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    tga_rle_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .take          (take),
        .hold_valid    (hold_valid),
        .hold_byte     (hold_byte)
    );

    tga_rle_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte),
        .out_free   (out_free),
        .take       (take),
        .res_load   (res_load),
        .res        (res)
    );

    tga_rle_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_load      (res_load),
        .res           (res),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
